// ===== src/crcfr_pkg.sv =====
// Shared types and constants for the CRC-16 framed packet receiver.
package crcfr_pkg;

    typedef enum logic [2:0] {
        PH_HUNT1   = 3'd0,
        PH_HUNT2   = 3'd1,
        PH_LEN     = 3'd2,
        PH_CODE    = 3'd3,
        PH_DATA    = 3'd4,
        PH_CRCLO   = 3'd5,
        PH_CRCHI   = 3'd6,
        PH_TRAILER = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_CRC     = 2'd1,
        ERR_TRAILER = 2'd2,
        ERR_LENGTH  = 2'd3
    } err_t;

    localparam logic [7:0]  HDR_BYTE     = 8'h7E;
    localparam logic [7:0]  TRAIL_A      = 8'h0D;
    localparam logic [7:0]  TRAIL_B      = 8'h0A;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [7:0]  MIN_LEN      = 8'd8;
    localparam logic [7:0]  MAX_LEN_RST  = 8'd128;

endpackage

// ===== src/crc16_framed_packet_receiver.sv =====
// Top level: byte-serial deframer for 7E 7E LEN CODE DATA CRC_LO CRC_HI 0D 0A packets.
//
// Accepts one received byte per clock and gives at most one result per byte: each
// data byte with its index and the frame code, and one closing result per frame with
// the verdict (CRC mismatch, bad trailer, or bad length, the latter reported right
// after the length byte). Sustained rate is one byte per cycle; a byte is held in the
// input register while the framing state machine and the byte-wide CRC update work
// on it, and its result is then registered in the result register. Backpressure on
// the result side stalls the input only when a byte that makes a result finds the
// result register still full. max_frame_length resets to 128 and is to be written
// with cfg_we while no frame is in flight; the block itself does not enforce this.
module crc16_framed_packet_receiver (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_payload_byte,
    output logic [7:0] m_payload_index,
    output logic [7:0] m_frame_code,
    output logic       m_is_last,
    output logic       m_frame_ok,
    output logic [1:0] m_error_kind
);
    import crcfr_pkg::*;

    logic [7:0]  max_len_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    phase_t      phase_reg, phase_next;
    logic [7:0]  frame_len_reg, frame_len_next;
    logic [7:0]  byte_pos_reg, byte_pos_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  code_reg, code_next;
    logic [15:0] rx_crc_reg, rx_crc_next;
    logic        trail_seen_reg, trail_seen_next;

    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic [7:0]  out_index_reg;
    logic [7:0]  out_code_reg;
    logic        out_last_reg;
    logic        out_ok_reg;
    err_t        out_err_reg;

    logic        produce;
    logic [7:0]  res_byte;
    logic [7:0]  res_index;
    logic [7:0]  res_code;
    logic        res_last;
    err_t        res_err;

    logic [15:0] crc_seed;
    logic [15:0] crc_upd;
    logic [8:0]  pos_inc;
    logic        advance;

    crcfr_crc_update u_crc (
        .crc_in  (crc_seed),
        .data_in (in_byte_reg),
        .crc_out (crc_upd)
    );

    assign crc_seed = (phase_reg == PH_HUNT1) ? CRC_INIT : crc_reg;
    assign pos_inc  = {1'b0, byte_pos_reg} + 9'd1;

    // A byte moves on unless it makes a result and the result slot is still held.
    assign advance = in_valid_reg && (!produce || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        phase_next      = phase_reg;
        frame_len_next  = frame_len_reg;
        byte_pos_next   = byte_pos_reg;
        crc_next        = crc_reg;
        code_next       = code_reg;
        rx_crc_next     = rx_crc_reg;
        trail_seen_next = trail_seen_reg;
        produce   = 1'b0;
        res_byte  = 8'h00;
        res_index = 8'h00;
        res_code  = 8'h00;
        res_last  = 1'b0;
        res_err   = ERR_NONE;
        case (phase_reg)
            PH_HUNT1: begin
                if (in_byte_reg == HDR_BYTE) begin
                    crc_next   = crc_upd;
                    phase_next = PH_HUNT2;
                end
            end
            PH_HUNT2: begin
                if (in_byte_reg == HDR_BYTE) begin
                    crc_next   = crc_upd;
                    phase_next = PH_LEN;
                end else begin
                    phase_next = PH_HUNT1;
                    crc_next   = CRC_INIT;
                end
            end
            PH_LEN: begin
                if (in_byte_reg < MIN_LEN || in_byte_reg > max_len_reg) begin
                    phase_next = PH_HUNT1;
                    crc_next   = CRC_INIT;
                    produce    = 1'b1;
                    res_last   = 1'b1;
                    res_err    = ERR_LENGTH;
                end else begin
                    frame_len_next = in_byte_reg;
                    crc_next       = crc_upd;
                    phase_next     = PH_CODE;
                end
            end
            PH_CODE: begin
                code_next     = in_byte_reg;
                crc_next      = crc_upd;
                byte_pos_next = 8'h00;
                phase_next    = (frame_len_reg == MIN_LEN) ? PH_CRCLO : PH_DATA;
            end
            PH_DATA: begin
                crc_next      = crc_upd;
                byte_pos_next = pos_inc[7:0];
                if (pos_inc + {1'b0, MIN_LEN} >= {1'b0, frame_len_reg}) begin
                    phase_next = PH_CRCLO;
                end
                produce   = 1'b1;
                res_byte  = in_byte_reg;
                res_index = byte_pos_reg;
                res_code  = code_reg;
            end
            PH_CRCLO: begin
                rx_crc_next = {8'h00, in_byte_reg};
                phase_next  = PH_CRCHI;
            end
            PH_CRCHI: begin
                rx_crc_next     = {in_byte_reg, rx_crc_reg[7:0]};
                byte_pos_next   = 8'h00;
                trail_seen_next = 1'b0;
                phase_next      = PH_TRAILER;
            end
            PH_TRAILER: begin
                if (byte_pos_reg == 8'h00) begin
                    trail_seen_next = (in_byte_reg == TRAIL_A);
                    byte_pos_next   = 8'h01;
                end else begin
                    produce  = 1'b1;
                    res_last = 1'b1;
                    res_code = code_reg;
                    if (!(trail_seen_reg && in_byte_reg == TRAIL_B)) begin
                        res_err = ERR_TRAILER;
                    end else if (rx_crc_reg != crc_reg) begin
                        res_err = ERR_CRC;
                    end else begin
                        res_err = ERR_NONE;
                    end
                    phase_next = PH_HUNT1;
                    crc_next   = CRC_INIT;
                end
            end
            default: begin
                phase_next = PH_HUNT1;
            end
        endcase
        // Returning to the hunt clears the whole frame context.
        if (phase_next == PH_HUNT1) begin
            frame_len_next  = 8'h00;
            byte_pos_next   = 8'h00;
            crc_next        = CRC_INIT;
            code_next       = 8'h00;
            rx_crc_next     = 16'h0000;
            trail_seen_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg    <= MAX_LEN_RST;
            in_valid_reg   <= 1'b0;
            phase_reg      <= PH_HUNT1;
            frame_len_reg  <= 8'h00;
            byte_pos_reg   <= 8'h00;
            crc_reg        <= CRC_INIT;
            code_reg       <= 8'h00;
            rx_crc_reg     <= 16'h0000;
            trail_seen_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                max_len_reg <= cfg_wdata;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                phase_reg      <= phase_next;
                frame_len_reg  <= frame_len_next;
                byte_pos_reg   <= byte_pos_next;
                crc_reg        <= crc_next;
                code_reg       <= code_next;
                rx_crc_reg     <= rx_crc_next;
                trail_seen_reg <= trail_seen_next;
            end
            if (advance && produce) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        if (advance && produce) begin
            out_byte_reg  <= res_byte;
            out_index_reg <= res_index;
            out_code_reg  <= res_code;
            out_last_reg  <= res_last;
            out_ok_reg    <= res_last && (res_err == ERR_NONE);
            out_err_reg   <= res_err;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_payload_byte  = out_byte_reg;
    assign m_payload_index = out_index_reg;
    assign m_frame_code    = out_code_reg;
    assign m_is_last       = out_last_reg;
    assign m_frame_ok      = out_ok_reg;
    assign m_error_kind    = out_err_reg;

`ifndef SYNTH
    // closing result never carries a data byte
    a_last_no_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_last) |-> (m_payload_byte == 8'h00 && m_payload_index == 8'h00))
        else $error("closing result carries data");

    a_data_no_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_is_last) |-> (!m_frame_ok && m_error_kind == ERR_NONE))
        else $error("data result carries a verdict");

    a_ok_no_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_ok) |-> (m_error_kind == ERR_NONE))
        else $error("ok frame with error code");

    a_hunt_crc_init: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_HUNT1) |-> (crc_reg == CRC_INIT && byte_pos_reg == 8'h00))
        else $error("hunt state with stale frame context");

    a_input_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("stalled input byte lost");
`endif

endmodule

// ===== src/crcfr_crc_update.sv =====
// Byte-wide CRC-16/MODBUS update, eight reflected shift steps unrolled.
module crcfr_crc_update (
    input  logic [15:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [15:0] crc_out
);
    import crcfr_pkg::*;

    always_comb begin
        logic [15:0] c;
        c = crc_in ^ {8'h00, data_in};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule
